[hw/rtl/conv3x3_kernel_filter_assert.svh]
// Assertion macros shared by the 3x3 convolution filter RTL.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef CONV3X3_KERNEL_FILTER_ASSERT_SVH
`define CONV3X3_KERNEL_FILTER_ASSERT_SVH

// Invariant that must hold at every clock edge outside reset.
`define C3KF_ASSERT_HOLDS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("invariant violated");

// Same-cycle implication.
`define C3KF_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication violated");

// Next-cycle implication.
`define C3KF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

[hw/rtl/c3kf_pkg.sv]
// Shared types and constants of the 3x3 convolution filter.
// Depends on nothing; used by the kernel ALU and the top-level filter.
`default_nettype none

package c3kf_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 12;
    localparam int MAX_WIDTH   = 2048;
    localparam int KERNEL_SIZE = 3;
    localparam int WIN_TAPS    = KERNEL_SIZE * KERNEL_SIZE;
    localparam int CENTER_TAP  = KERNEL_SIZE + 1;
    localparam int RING_DEPTH  = 2 * MAX_WIDTH;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = CFG_W;
    localparam int EMIT_W      = 2 * CFG_W - 1;
    localparam int FED_W       = 2 * CFG_W;

    typedef logic [PIX_W-1:0]    pix_t;
    typedef logic [CFG_W-1:0]    cfg_t;
    typedef logic [1:0]          cfg_index_t;
    typedef logic [RING_AW-1:0]  addr_t;
    typedef logic [RING_AW:0]    ring_t;
    typedef logic [COL_W-1:0]    col_t;
    typedef logic [ROW_W-1:0]    row_t;
    typedef logic [EMIT_W-1:0]   emit_t;
    typedef logic [FED_W-1:0]    fed_t;
    typedef pix_t [WIN_TAPS-1:0] window_t;

    localparam cfg_index_t CFG_IDX_WIDTH  = 2'd0;
    localparam cfg_index_t CFG_IDX_HEIGHT = 2'd1;
    localparam cfg_index_t CFG_IDX_KERNEL = 2'd2;

    localparam cfg_t RESET_WIDTH  = 12'd640;
    localparam cfg_t RESET_HEIGHT = 12'd480;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // floor(s / 9) == (s * 7282) >> 16 for every s below 32768
    localparam logic [12:0] DIV9_MULT  = 13'd7282;
    localparam int          DIV9_SHIFT = 16;

    localparam pix_t PIX_MAX = 8'd255;

    typedef enum logic [1:0] {
        KERNEL_BOX,
        KERNEL_GAUSS,
        KERNEL_OUTLINE,
        KERNEL_EMBOSS
    } kernel_t;

    typedef struct packed {
        logic mode;
        pix_t pixel_in;
    } in_word_t;

    typedef struct packed {
        pix_t pixel_out;
        logic frame_end;
    } out_word_t;

    typedef struct packed {
        kernel_t kernel;
        logic    border;
    } alu_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/c3kf_line_ram.sv]
// Generic one-write, two-read RAM with registered, enabled read ports.
// Read-first on a shared address. Depends on nothing.
`default_nettype none

module c3kf_line_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/c3kf_kernel_alu.sv]
// Kernel datapath: box, Gaussian, outline and emboss over the 3x3 window,
// clamped to a byte, with border pass-through. Depends on c3kf_pkg.
`default_nettype none

module c3kf_kernel_alu (
    input  c3kf_pkg::window_t  win,
    input  c3kf_pkg::alu_ctl_t ctl,
    output c3kf_pkg::pix_t     pix
);

    function automatic c3kf_pkg::pix_t clamp_byte(input logic signed [12:0] v);
        c3kf_pkg::pix_t r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({5'b0, c3kf_pkg::PIX_MAX})) begin
            r = c3kf_pkg::PIX_MAX;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    logic [9:0]         corner_sum;
    logic [9:0]         side_sum;
    logic [11:0]        box_sum;
    logic [24:0]        box_prod;
    logic [11:0]        gauss_sum;
    logic [11:0]        center_x9;
    logic signed [12:0] outline_val;
    logic [10:0]        emb_pos;
    logic [9:0]         emb_neg;
    logic signed [11:0] emboss_val;
    c3kf_pkg::pix_t     conv_pix;

    always_comb begin
        corner_sum = {2'b0, win[0]} + {2'b0, win[2]} + {2'b0, win[6]} + {2'b0, win[8]};
        side_sum   = {2'b0, win[1]} + {2'b0, win[3]} + {2'b0, win[5]} + {2'b0, win[7]};
        box_sum    = {2'b0, corner_sum} + {2'b0, side_sum} + {4'b0, win[4]};
        box_prod   = {13'b0, box_sum} * {12'b0, c3kf_pkg::DIV9_MULT};
        gauss_sum  = {2'b0, corner_sum} + {1'b0, side_sum, 1'b0} + {2'b0, win[4], 2'b0};
        // 9*center - sum of all taps is 8*center minus the neighbours
        center_x9   = {1'b0, win[4], 3'b0} + {4'b0, win[4]};
        outline_val = $signed({1'b0, center_x9}) - $signed({1'b0, box_sum});
        emb_pos     = {3'b0, win[4]} + {3'b0, win[5]} + {3'b0, win[7]} + {2'b0, win[8], 1'b0};
        emb_neg     = {1'b0, win[0], 1'b0} + {2'b0, win[1]} + {2'b0, win[3]};
        emboss_val  = $signed({1'b0, emb_pos}) - $signed({2'b0, emb_neg});

        unique case (ctl.kernel)
            c3kf_pkg::KERNEL_BOX:     conv_pix = box_prod[c3kf_pkg::DIV9_SHIFT +: 8];
            c3kf_pkg::KERNEL_GAUSS:   conv_pix = gauss_sum[11:4];
            c3kf_pkg::KERNEL_OUTLINE: conv_pix = clamp_byte(outline_val);
            c3kf_pkg::KERNEL_EMBOSS:  conv_pix = clamp_byte({emboss_val[11], emboss_val});
        endcase

        pix = ctl.border ? win[c3kf_pkg::CENTER_TAP] : conv_pix;
    end

endmodule

`default_nettype wire

[hw/rtl/conv3x3_kernel_filter.sv]
// The word completing a window passes the read stage, window stage and output
//   register to m_data; pixel k of a frame is completed by word k+W+1.
// Throughput: one word per clock unless m_ready stalls, set by the line store RAM (one write, two reads).
// Reset (aresetn low, synchronous): counters and valids clear, registers load
//   640x480 box blur; line store and window are not cleared (stale data only
//   ever reaches border positions, which pass the center pixel through).
`default_nettype none
`include "conv3x3_kernel_filter_assert.svh"

module conv3x3_kernel_filter (
    input  logic                   aclk,
    input  logic                   aresetn,
    // pixel / flush words in
    input  logic                   s_valid,
    output logic                   s_ready,
    input  c3kf_pkg::in_word_t     s_data,
    // filtered pixels out
    output logic                   m_valid,
    input  logic                   m_ready,
    output c3kf_pkg::out_word_t    m_data,
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  c3kf_pkg::cfg_index_t   cfg_index,
    input  c3kf_pkg::cfg_t         cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    c3kf_pkg::cfg_t    width_reg;
    c3kf_pkg::cfg_t    height_reg;
    c3kf_pkg::kernel_t kernel_reg;
    logic              cfg_fire;
    logic              cfg_restart;

    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_fire &&
                         (cfg_index == c3kf_pkg::CFG_IDX_WIDTH ||
                          cfg_index == c3kf_pkg::CFG_IDX_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= c3kf_pkg::RESET_WIDTH;
            height_reg <= c3kf_pkg::RESET_HEIGHT;
            kernel_reg <= c3kf_pkg::KERNEL_BOX;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                c3kf_pkg::CFG_IDX_WIDTH:  width_reg  <= cfg_data;
                c3kf_pkg::CFG_IDX_HEIGHT: height_reg <= cfg_data;
                c3kf_pkg::CFG_IDX_KERNEL: kernel_reg <= c3kf_pkg::kernel_t'(cfg_data[1:0]);
                default: ; // drop writes past the register list
            endcase
        end
    end

    // Effective geometry: zero reads as one, width saturates at MAX_WIDTH, one row of the line store.
    c3kf_pkg::cfg_t  eff_w;
    c3kf_pkg::cfg_t  eff_h;
    c3kf_pkg::emit_t total_prod;
    c3kf_pkg::emit_t total;
    c3kf_pkg::ring_t ring;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = c3kf_pkg::cfg_t'(1);
        end else if (width_reg > c3kf_pkg::cfg_t'(c3kf_pkg::MAX_WIDTH)) begin
            eff_w = c3kf_pkg::cfg_t'(c3kf_pkg::MAX_WIDTH);
        end else begin
            eff_w = width_reg;
        end
        eff_h      = (height_reg == '0) ? c3kf_pkg::cfg_t'(1) : height_reg;
        total_prod = c3kf_pkg::emit_t'(eff_w) * c3kf_pkg::emit_t'(eff_h);
        total      = total_prod;
        ring       = {eff_w, 1'b0};
    end

    // ---------------------------------------------------------------
    // Handshake chain: output register <- window stage <- read stage
    // ---------------------------------------------------------------
    logic m_valid_reg;
    logic a_valid_reg;
    logic b_valid_reg;
    logic out_free;
    logic b_adv;
    logic b_free;
    logic a_adv;

    assign out_free = !m_valid_reg || m_ready;
    assign b_adv    = b_valid_reg && out_free;
    assign b_free   = !b_valid_reg || b_adv;
    assign a_adv    = a_valid_reg && b_free;
    assign s_ready  = !a_valid_reg || a_adv;

    // ---------------------------------------------------------------
    // Accept: frame counters, line store addressing
    // ---------------------------------------------------------------
    c3kf_pkg::fed_t  fed_reg,     fed_next;
    c3kf_pkg::emit_t emitted_reg, emitted_next;
    c3kf_pkg::col_t  col_reg,     col_next;
    c3kf_pkg::row_t  row_reg,     row_next;
    c3kf_pkg::addr_t wr_ptr_reg,  wr_ptr_next;

    logic            s_fire;
    logic            take;
    logic            take_emit;
    logic            take_border;
    logic            take_fend;
    c3kf_pkg::pix_t  take_value;
    c3kf_pkg::fed_t  fed_inc;
    c3kf_pkg::fed_t  emit_start;
    c3kf_pkg::cfg_t  col_inc;
    logic [12:0]     row_inc;
    c3kf_pkg::ring_t wr_inc;
    c3kf_pkg::addr_t mid_addr;

    always_comb begin
        s_fire = s_valid && s_ready;
        // pixels only until the frame is complete, flushes only afterwards
        if (s_data.mode == c3kf_pkg::MODE_FLUSH) begin
            take = s_fire && (fed_reg >= c3kf_pkg::fed_t'(total));
        end else begin
            take = s_fire && (fed_reg < c3kf_pkg::fed_t'(total));
        end
        take_value = (s_data.mode == c3kf_pkg::MODE_FLUSH) ? '0 : s_data.pixel_in;

        fed_inc    = fed_reg + c3kf_pkg::fed_t'(1);
        emit_start = c3kf_pkg::fed_t'(eff_w) + c3kf_pkg::fed_t'(2);
        take_emit  = fed_inc >= emit_start;

        col_inc     = {1'b0, col_reg} + c3kf_pkg::cfg_t'(1);
        row_inc     = {1'b0, row_reg} + 13'd1;
        take_border = (row_reg == '0) || (row_inc >= {1'b0, eff_h}) ||
                      (col_reg == '0) || (col_inc >= eff_w);
        take_fend   = (emitted_reg + c3kf_pkg::emit_t'(1)) == total;

        // ring of 2W entries: top row at the write slot, middle row W slots on
        wr_inc   = {1'b0, wr_ptr_reg} + c3kf_pkg::ring_t'(1);
        mid_addr = (wr_ptr_reg >= c3kf_pkg::addr_t'(eff_w)) ?
                   wr_ptr_reg - c3kf_pkg::addr_t'(eff_w) :
                   wr_ptr_reg + c3kf_pkg::addr_t'(eff_w);
    end

    always_comb begin
        fed_next     = fed_reg;
        emitted_next = emitted_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        wr_ptr_next  = wr_ptr_reg;
        if (cfg_restart) begin
            // abandon the current frame
            fed_next     = '0;
            emitted_next = '0;
            col_next     = '0;
            row_next     = '0;
            wr_ptr_next  = '0;
        end else if (take) begin
            fed_next    = fed_inc;
            wr_ptr_next = (wr_inc >= ring) ? '0 : wr_inc[c3kf_pkg::RING_AW-1:0];
            if (take_emit) begin
                emitted_next = emitted_reg + c3kf_pkg::emit_t'(1);
                if (col_inc >= eff_w) begin
                    col_next = '0;
                    row_next = row_inc[c3kf_pkg::ROW_W-1:0];
                end else begin
                    col_next = col_inc[c3kf_pkg::COL_W-1:0];
                end
                if (take_fend) begin
                    // last pixel out: next word starts a new frame
                    fed_next     = '0;
                    emitted_next = '0;
                    col_next     = '0;
                    row_next     = '0;
                    wr_ptr_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fed_reg     <= '0;
            emitted_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            wr_ptr_reg  <= '0;
        end else begin
            fed_reg     <= fed_next;
            emitted_reg <= emitted_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            wr_ptr_reg  <= wr_ptr_next;
        end
    end

    // Line store: two rows of history, read and written on the accepting edge.
    c3kf_pkg::pix_t top_pix;
    c3kf_pkg::pix_t mid_pix;

    c3kf_line_ram #(
        .DEPTH (c3kf_pkg::RING_DEPTH),
        .WIDTH (c3kf_pkg::PIX_W)
    ) u_line_ram (
        .aclk      (aclk),
        .wr_en     (take),
        .wr_addr   (wr_ptr_reg),
        .wr_data   (take_value),
        .rd_en     (take),
        .rd_addr_a (wr_ptr_reg),
        .rd_addr_b (mid_addr),
        .rd_data_a (top_pix),
        .rd_data_b (mid_pix)
    );

    // ---------------------------------------------------------------
    // Read stage: the accepted word waits here for its line store data
    // ---------------------------------------------------------------
    logic           a_valid_next;
    c3kf_pkg::pix_t a_value_reg;
    logic           a_emit_reg;
    logic           a_border_reg;
    logic           a_fend_reg;

    always_comb begin
        if (take) begin
            a_valid_next = 1'b1;
        end else if (a_adv) begin
            a_valid_next = 1'b0;
        end else begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            a_value_reg  <= take_value;
            a_emit_reg   <= take_emit;
            a_border_reg <= take_border;
            a_fend_reg   <= take_fend;
        end
    end

    // ---------------------------------------------------------------
    // Window stage: shift in the new column; only emitting words occupy it
    // ---------------------------------------------------------------
    c3kf_pkg::window_t win_reg, win_next;
    logic              b_valid_next;
    logic              b_border_reg;
    logic              b_fend_reg;

    always_comb begin
        for (int r = 0; r < c3kf_pkg::KERNEL_SIZE; r++) begin
            for (int c = 0; c < c3kf_pkg::KERNEL_SIZE - 1; c++) begin
                win_next[r * c3kf_pkg::KERNEL_SIZE + c] =
                    win_reg[r * c3kf_pkg::KERNEL_SIZE + c + 1];
            end
        end
        win_next[c3kf_pkg::KERNEL_SIZE - 1]     = top_pix;
        win_next[2 * c3kf_pkg::KERNEL_SIZE - 1] = mid_pix;
        win_next[c3kf_pkg::WIN_TAPS - 1]        = a_value_reg;
    end

    always_comb begin
        if (a_adv) begin
            b_valid_next = a_emit_reg;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end else begin
            b_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv) begin
            win_reg      <= win_next;
            b_border_reg <= a_border_reg;
            b_fend_reg   <= a_fend_reg;
        end
    end

    // ---------------------------------------------------------------
    // Kernel and output register
    // ---------------------------------------------------------------
    c3kf_pkg::alu_ctl_t  alu_ctl;
    c3kf_pkg::pix_t      alu_pix;
    logic                m_valid_next;
    c3kf_pkg::out_word_t m_data_reg;

    assign alu_ctl.kernel = kernel_reg;
    assign alu_ctl.border = b_border_reg;

    c3kf_kernel_alu u_kernel_alu (
        .win (win_reg),
        .ctl (alu_ctl),
        .pix (alu_pix)
    );

    assign m_valid_next = out_free ? b_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the word until it is taken
    always_ff @(posedge aclk) begin
        if (b_adv) begin
            m_data_reg.pixel_out <= alu_pix;
            m_data_reg.frame_end <= b_fend_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic frame_done;
    logic counters_clear;
    logic a_blocked;
    logic out_stalled;

    assign frame_done     = take && take_emit && take_fend;
    assign counters_clear = (fed_reg == '0) && (emitted_reg == '0) && (row_reg == '0);
    assign a_blocked      = a_valid_reg && !a_adv;
    assign out_stalled    = b_valid_reg && m_valid_reg && !m_ready;

    `C3KF_ASSERT_HOLDS(a_emitted_below_total, aclk, aresetn, emitted_reg < total)
    `C3KF_ASSERT_HOLDS(a_wr_ptr_in_ring, aclk, aresetn, {1'b0, wr_ptr_reg} < ring)
    `C3KF_ASSERT_HOLDS(a_col_in_row, aclk, aresetn, {1'b0, col_reg} < eff_w)
    `C3KF_ASSERT_NEXT(a_frame_restart, aclk, aresetn, frame_done, counters_clear)
    `C3KF_ASSERT_IMPLIES(a_stall_from_output, aclk, aresetn, a_blocked, out_stalled)

endmodule

`default_nettype wire
